@@ hdl/lia_pkg.sv @@
// ----------------------------------------------------------------------------
// lia_pkg
// Shared types, codes and constants of the load instruction address unit.
// ----------------------------------------------------------------------------
package lia_pkg;

  // Item phases of the multi-transfer instructions
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DATA = 2'd1,
    PH_PLO  = 2'd2,
    PH_PHI  = 2'd3
  } phase_e;

  // Addressing modes
  typedef enum logic [3:0] {
    M_BAD  = 4'd0,
    M_IMM  = 4'd1,
    M_ZP   = 4'd2,
    M_ZPX  = 4'd3,
    M_ZPY  = 4'd4,
    M_ABS  = 4'd5,
    M_ABSX = 4'd6,
    M_ABSY = 4'd7,
    M_INDX = 4'd8,
    M_INDY = 4'd9
  } mode_e;

  // Item kinds
  localparam logic KIND_INSTR = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  // Target register codes
  localparam logic [1:0] TGT_Y = 2'd0;
  localparam logic [1:0] TGT_A = 2'd1;
  localparam logic [1:0] TGT_X = 2'd2;

  // Base cycle counts
  localparam logic [2:0] CYC_IMM  = 3'd2;
  localparam logic [2:0] CYC_ZP   = 3'd3;
  localparam logic [2:0] CYC_ZPI  = 3'd4;
  localparam logic [2:0] CYC_ABS  = 3'd4;
  localparam logic [2:0] CYC_ABSP = 3'd5;
  localparam logic [2:0] CYC_INDX = 3'd6;
  localparam logic [2:0] CYC_INDY = 3'd5;

  typedef struct packed {
    logic       kind;
    logic [7:0] opcode;
    logic [7:0] operand_low;
    logic [7:0] operand_high;
    logic [7:0] read_data;
  } item_t;

  typedef struct packed {
    logic        read_request;
    logic [15:0] address;
    logic        done_res;
    logic [1:0]  target_reg;
    logic [7:0]  loaded_value;
    logic        negative_flag;
    logic        zero_flag;
    logic [2:0]  cycle_total;
    logic        error;
  } result_t;

  // Architectural and sequencing state. The pointer always lies in page zero.
  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    logic       neg;
    logic       zero;
    phase_e     phase;
    logic [1:0] pend_tgt;
    logic       indy;
    logic [7:0] ptr_addr;
    logic [7:0] ptr_low;
    logic [2:0] cyc;
  } state_t;

  localparam state_t STATE_RESET = '{
    acc:      8'h00,
    x:        8'h00,
    y:        8'h00,
    neg:      1'b0,
    zero:     1'b0,
    phase:    PH_IDLE,
    pend_tgt: 2'd0,
    indy:     1'b0,
    ptr_addr: 8'h00,
    ptr_low:  8'h00,
    cyc:      3'd0
  };

  function automatic mode_e mode_of(input logic [7:0] op);
    mode_e m;
    case (op)
      8'hA9, 8'hA2, 8'hA0: m = M_IMM;
      8'hA5, 8'hA6, 8'hA4: m = M_ZP;
      8'hB5, 8'hB4:        m = M_ZPX;
      8'hB6:               m = M_ZPY;
      8'hAD, 8'hAE, 8'hAC: m = M_ABS;
      8'hBD, 8'hBC:        m = M_ABSX;
      8'hB9, 8'hBE:        m = M_ABSY;
      8'hA1:               m = M_INDX;
      8'hB1:               m = M_INDY;
      default:             m = M_BAD;
    endcase
    return m;
  endfunction

endpackage

@@ hdl/lia_regfile.sv @@
// ----------------------------------------------------------------------------
// lia_regfile
// A/X/Y, N/Z flags and instruction sequencing state, updated per item.
// ----------------------------------------------------------------------------
module lia_regfile (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  lia_pkg::state_t state_d_i,
  output lia_pkg::state_t state_q_o
);

  lia_pkg::state_t state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lia_pkg::STATE_RESET;
    end else if (en_i) begin
      state_q <= state_d_i;
    end
  end

  assign state_q_o = state_q;

endmodule

@@ hdl/lia_exec.sv @@
// ----------------------------------------------------------------------------
// lia_exec
// Combinational execute step: decode, address generation, register write.
// ----------------------------------------------------------------------------
module lia_exec (
  input  lia_pkg::item_t   item_i,
  input  lia_pkg::state_t  state_i,
  output lia_pkg::state_t  state_d_o,
  output lia_pkg::result_t res_o
);

  always_comb begin
    lia_pkg::mode_e   mode;
    lia_pkg::state_t  st;
    lia_pkg::result_t res;
    logic [7:0]       idx;
    logic [8:0]       sum9;
    logic             done_en;
    logic [1:0]       done_tgt;
    logic [7:0]       done_val;
    logic [2:0]       done_cyc;

    mode     = lia_pkg::mode_of(item_i.opcode);
    st       = state_i;
    res      = '0;
    idx      = 8'h00;
    sum9     = 9'd0;
    done_en  = 1'b0;
    done_tgt = item_i.opcode[1:0];
    done_val = item_i.operand_low;
    done_cyc = lia_pkg::CYC_IMM;

    if (item_i.kind == lia_pkg::KIND_INSTR) begin
      if (state_i.phase != lia_pkg::PH_IDLE) begin
        res.error = 1'b1;
      end else begin
        case (mode)
          lia_pkg::M_IMM: begin
            done_en = 1'b1;
          end
          lia_pkg::M_ZP, lia_pkg::M_ZPX, lia_pkg::M_ZPY: begin
            idx = (mode == lia_pkg::M_ZPX) ? state_i.x :
                  (mode == lia_pkg::M_ZPY) ? state_i.y : 8'h00;
            st.cyc = (mode == lia_pkg::M_ZP) ? lia_pkg::CYC_ZP : lia_pkg::CYC_ZPI;
            st.pend_tgt = item_i.opcode[1:0];
            st.phase = lia_pkg::PH_DATA;
            res.read_request = 1'b1;
            res.address = {8'h00, 8'(item_i.operand_low + idx)};
          end
          lia_pkg::M_ABS, lia_pkg::M_ABSX, lia_pkg::M_ABSY: begin
            idx = (mode == lia_pkg::M_ABSX) ? state_i.x :
                  (mode == lia_pkg::M_ABSY) ? state_i.y : 8'h00;
            sum9 = {1'b0, item_i.operand_low} + {1'b0, idx};
            st.cyc = sum9[8] ? lia_pkg::CYC_ABSP : lia_pkg::CYC_ABS;
            st.pend_tgt = item_i.opcode[1:0];
            st.phase = lia_pkg::PH_DATA;
            res.read_request = 1'b1;
            res.address = {8'(item_i.operand_high + {7'd0, sum9[8]}), sum9[7:0]};
          end
          lia_pkg::M_INDX, lia_pkg::M_INDY: begin
            st.pend_tgt = lia_pkg::TGT_A;
            if (mode == lia_pkg::M_INDX) begin
              st.ptr_addr = 8'(item_i.operand_low + state_i.x);
              st.indy = 1'b0;
              st.cyc = lia_pkg::CYC_INDX;
            end else begin
              st.ptr_addr = item_i.operand_low;
              st.indy = 1'b1;
              st.cyc = lia_pkg::CYC_INDY;
            end
            st.phase = lia_pkg::PH_PLO;
            res.read_request = 1'b1;
            res.address = {8'h00, st.ptr_addr};
          end
          default: begin
            res.error = 1'b1;
          end
        endcase
      end
    end else begin
      case (state_i.phase)
        lia_pkg::PH_DATA: begin
          st.phase = lia_pkg::PH_IDLE;
          done_en  = 1'b1;
          done_tgt = state_i.pend_tgt;
          done_val = item_i.read_data;
          done_cyc = state_i.cyc;
        end
        lia_pkg::PH_PLO: begin
          st.ptr_low = item_i.read_data;
          st.phase = lia_pkg::PH_PHI;
          res.read_request = 1'b1;
          res.address = {8'h00, 8'(state_i.ptr_addr + 8'd1)};
        end
        lia_pkg::PH_PHI: begin
          // (zp),Y adds Y across the page; carry bumps the high byte and the count
          sum9 = {1'b0, state_i.ptr_low} + {1'b0, (state_i.indy ? state_i.y : 8'h00)};
          if (sum9[8]) begin
            st.cyc = 3'(state_i.cyc + 3'd1);
          end
          st.phase = lia_pkg::PH_DATA;
          res.read_request = 1'b1;
          res.address = {8'(item_i.read_data + {7'd0, sum9[8]}), sum9[7:0]};
        end
        default: begin
          res.error = 1'b1;
        end
      endcase
    end

    if (done_en) begin
      case (done_tgt)
        lia_pkg::TGT_Y: st.y = done_val;
        lia_pkg::TGT_A: st.acc = done_val;
        default:        st.x = done_val;
      endcase
      st.neg  = done_val[7];
      st.zero = (done_val == 8'h00);
      res.done_res      = 1'b1;
      res.target_reg    = done_tgt;
      res.loaded_value  = done_val;
      res.negative_flag = done_val[7];
      res.zero_flag     = (done_val == 8'h00);
      res.cycle_total   = done_cyc;
    end

    state_d_o = st;
    res_o     = res;
  end

endmodule

@@ hdl/load_instruction_address_unit_top.sv @@
// ----------------------------------------------------------------------------
// load_instruction_address_unit_top
// LDA/LDX/LDY execute unit with address generation and read sequencing.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries either a new instruction
//   (kind 0: opcode plus operand bytes) or a byte returned by memory for the
//   last read request (kind 1). Every input transfer produces exactly one
//   output transfer on out_valid_o/out_ready_i: a read request with its
//   address, a done record (target, value, N/Z, cycle count), or an error.
//   The caller answers each read request by sending the memory byte back as
//   a kind 1 item.
//   Path: an item is captured in the input register, executed by the
//   combinational execute step and captured in the result register.
//   Throughput: one item per cycle while the output is not stalled; the
//   input register and the result register are separate stages, with the
//   single execute step between them.
//   Reset: A, X, Y, N, Z and the sequencer clear; the unit starts idle with
//   both stages empty.
//   Output stall: the result holds until transferred; one further item waits
//   in the input register, after which in_ready_o drops.
// ----------------------------------------------------------------------------
module load_instruction_address_unit_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [7:0]  opcode_i,
  input  logic [7:0]  operand_low_i,
  input  logic [7:0]  operand_high_i,
  input  logic [7:0]  read_data_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        read_request_o,
  output logic [15:0] address_o,
  output logic        done_res_o,
  output logic [1:0]  target_reg_o,
  output logic [7:0]  loaded_value_o,
  output logic        negative_flag_o,
  output logic        zero_flag_o,
  output logic [2:0]  cycle_total_o,
  output logic        error_o
);

  lia_pkg::item_t   in_q;
  logic             in_vld_q;
  lia_pkg::result_t res_q;
  lia_pkg::result_t res_d;
  logic             out_vld_q;
  lia_pkg::state_t  state_q;
  lia_pkg::state_t  state_d;
  logic             advance;
  logic             in_xfer;

  // Execute the registered item when the result register is free or draining
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_xfer) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= '{kind:         kind_i,
                opcode:       opcode_i,
                operand_low:  operand_low_i,
                operand_high: operand_high_i,
                read_data:    read_data_i};
    end
  end

  lia_exec u_exec (
    .item_i    (in_q),
    .state_i   (state_q),
    .state_d_o (state_d),
    .res_o     (res_d)
  );

  // State commits once per executed item, in item order
  lia_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .state_d_i (state_d),
    .state_q_o (state_q)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign read_request_o  = res_q.read_request;
  assign address_o       = res_q.address;
  assign done_res_o      = res_q.done_res;
  assign target_reg_o    = res_q.target_reg;
  assign loaded_value_o  = res_q.loaded_value;
  assign negative_flag_o = res_q.negative_flag;
  assign zero_flag_o     = res_q.zero_flag;
  assign cycle_total_o   = res_q.cycle_total;
  assign error_o         = res_q.error;

  // Assertions
  a_kind_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($countones({read_request_o, done_res_o, error_o}) == 1))
    else $error("result is not exactly one of read, done, error");

  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_d.read_request) |=> (state_q.phase != lia_pkg::PH_IDLE))
    else $error("read request issued but sequencer idle");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_d.done_res) |=> (state_q.phase == lia_pkg::PH_IDLE))
    else $error("done issued but sequencer still busy");

  a_cyc_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && done_res_o) |-> (cycle_total_o >= lia_pkg::CYC_IMM))
    else $error("cycle total below minimum");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_vld_q && out_vld_q && !out_ready_i))
    else $error("input stalled with a free stage");

endmodule
